>>> hw/rtl/epbsbo_pkg.sv
// Shared constants, register codes and types for the slice bit offset corrector.
package epbsbo_pkg;

    // Width of the stored header bit offset
    localparam int OFFSET_BITS = 16;
    // Byte position width and test position width (one spare bit for the +3 step)
    localparam int POS_W       = 24;
    localparam int NTP_W       = POS_W + 1;
    // Header length in bytes and header byte counter widths
    localparam int HS_W        = OFFSET_BITS - 3;
    localparam int HBS_W       = HS_W + 1;
    // Result widths
    localparam int CNT_W       = 13;
    localparam int OUT_W       = 17;
    // Sum width for offset + 8*count, with room for the round-up
    localparam int SUM_W       = ((OFFSET_BITS > CNT_W + 3) ? OFFSET_BITS : CNT_W + 3) + 2;

    // Configuration port widths
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [7:0]       EPB_BYTE   = 8'h03;
    localparam logic [7:0]       ZERO_BYTE  = 8'h00;
    localparam logic [NTP_W-1:0] TEST_START = NTP_W'(2);
    localparam logic [HBS_W-1:0] HDR_START  = HBS_W'(2);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_OFFSET = 2'd0,
        CFG_DATA_LEN   = 2'd1,
        CFG_CABAC      = 2'd2
    } cfg_idx_t;

    // Current configuration
    typedef struct packed {
        logic [OFFSET_BITS-1:0] header_bit_offset;
        logic [POS_W-1:0]       slice_data_len;
        logic                   cabac_mode;
    } cfg_t;

    // Scan outcome for one processed byte
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } scan_res_t;

endpackage

>>> hw/rtl/epbsbo_cfg.sv
// Configuration register file for the slice bit offset corrector.
module epbsbo_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [epbsbo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epbsbo_pkg::CFG_DATA_W-1:0]   cfg_data,
    output epbsbo_pkg::cfg_t                    cfg
);

    epbsbo_pkg::cfg_t cfg_reg;
    epbsbo_pkg::cfg_t cfg_next;

    // Writes are always accepted
    assign cfg_ready = 1'b1;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                epbsbo_pkg::CFG_HDR_OFFSET:
                    cfg_next.header_bit_offset = cfg_data[epbsbo_pkg::OFFSET_BITS-1:0];
                epbsbo_pkg::CFG_DATA_LEN:
                    cfg_next.slice_data_len = cfg_data[epbsbo_pkg::POS_W-1:0];
                epbsbo_pkg::CFG_CABAC:
                    cfg_next.cabac_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/epbsbo_scan.sv
// Emulation prevention byte scan: per-byte state update and end-of-header detection.
module epbsbo_scan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    first_byte,
    input  epbsbo_pkg::cfg_t        cfg,
    output epbsbo_pkg::scan_res_t   res
);

    logic [epbsbo_pkg::POS_W-1:0] bp_reg, bp_next;
    logic [epbsbo_pkg::NTP_W-1:0] ntp_reg, ntp_next;
    logic [epbsbo_pkg::HBS_W-1:0] hbs_reg, hbs_next;
    logic [epbsbo_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                   prev0_reg, prev0_next;
    logic [7:0]                   prev1_reg, prev1_next;
    logic                         done_reg, done_next;

    logic [epbsbo_pkg::HS_W-1:0]  hs;
    logic [epbsbo_pkg::HS_W+1:0]  lim3;
    logic [epbsbo_pkg::NTP_W-1:0] lim_hdr;
    logic [epbsbo_pkg::NTP_W-1:0] lim_data;
    logic [epbsbo_pkg::NTP_W-1:0] lim;
    logic                         emit;

    // Header length and scan limit: min((3*hs + 1) / 2, slice_data_len)
    always_comb
    begin
        hs       = cfg.header_bit_offset[epbsbo_pkg::OFFSET_BITS-1:3];
        lim3     = ((epbsbo_pkg::HS_W+2)'(hs) << 1) + (epbsbo_pkg::HS_W+2)'(hs)
                   + (epbsbo_pkg::HS_W+2)'(1);
        lim_hdr  = epbsbo_pkg::NTP_W'(lim3[epbsbo_pkg::HS_W+1:1]);
        lim_data = epbsbo_pkg::NTP_W'(cfg.slice_data_len);
        lim      = (lim_hdr > lim_data) ? lim_data : lim_hdr;
    end

    // One byte of scan
    always_comb
    begin
        logic [epbsbo_pkg::POS_W-1:0] bp_b;
        logic [epbsbo_pkg::NTP_W-1:0] ntp_b;
        logic [epbsbo_pkg::HBS_W-1:0] hbs_b;
        logic [epbsbo_pkg::CNT_W-1:0] cnt_b;
        logic [7:0]                   p0_b;
        logic [7:0]                   p1_b;
        logic                         run;

        bp_next    = bp_reg;
        ntp_next   = ntp_reg;
        hbs_next   = hbs_reg;
        cnt_next   = cnt_reg;
        prev0_next = prev0_reg;
        prev1_next = prev1_reg;
        done_next  = done_reg;
        emit       = 1'b0;

        // A first byte restarts the scan from fresh values
        if (first_byte)
        begin
            bp_b  = '0;
            ntp_b = epbsbo_pkg::TEST_START;
            hbs_b = epbsbo_pkg::HDR_START;
            cnt_b = '0;
            p0_b  = epbsbo_pkg::ZERO_BYTE;
            p1_b  = epbsbo_pkg::ZERO_BYTE;
            run   = 1'b1;
        end
        else
        begin
            bp_b  = bp_reg;
            ntp_b = ntp_reg;
            hbs_b = hbs_reg;
            cnt_b = cnt_reg;
            p0_b  = prev0_reg;
            p1_b  = prev1_reg;
            run   = !done_reg;
        end

        if (step && run)
        begin
            ntp_next = ntp_b;
            hbs_next = hbs_b;
            cnt_next = cnt_b;

            // Test the byte at the current test position
            if ((epbsbo_pkg::NTP_W'(bp_b) == ntp_b) && (ntp_b < lim)
                && (hbs_b < epbsbo_pkg::HBS_W'(hs)))
            begin
                if ((data_byte == epbsbo_pkg::EPB_BYTE) && (p0_b == epbsbo_pkg::ZERO_BYTE)
                    && (p1_b == epbsbo_pkg::ZERO_BYTE))
                begin
                    ntp_next = ntp_b + epbsbo_pkg::NTP_W'(3);
                    hbs_next = hbs_b + epbsbo_pkg::HBS_W'(2);
                    if (cnt_b != epbsbo_pkg::CNT_MAX)
                    begin
                        cnt_next = cnt_b + epbsbo_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    ntp_next = ntp_b + epbsbo_pkg::NTP_W'(1);
                    hbs_next = hbs_b + epbsbo_pkg::HBS_W'(1);
                end
            end

            prev1_next = p0_b;
            prev0_next = data_byte;
            bp_next    = (bp_b != epbsbo_pkg::POS_MAX) ? bp_b + epbsbo_pkg::POS_W'(1) : bp_b;

            // Header end or scan limit reached: emit and go idle
            emit      = !((ntp_next < lim) && (hbs_next < epbsbo_pkg::HBS_W'(hs)));
            done_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg    <= '0;
            ntp_reg   <= epbsbo_pkg::TEST_START;
            hbs_reg   <= epbsbo_pkg::HDR_START;
            cnt_reg   <= '0;
            prev0_reg <= epbsbo_pkg::ZERO_BYTE;
            prev1_reg <= epbsbo_pkg::ZERO_BYTE;
            done_reg  <= 1'b1;
        end
        else
        begin
            bp_reg    <= bp_next;
            ntp_reg   <= ntp_next;
            hbs_reg   <= hbs_next;
            cnt_reg   <= cnt_next;
            prev0_reg <= prev0_next;
            prev1_reg <= prev1_next;
            done_reg  <= done_next;
        end
    end

    assign res.valid = emit;
    assign res.count = cnt_next;

`ifndef SYNTHESIS
    // The scan only leaves idle on an accepted first byte
    a_start_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(done_reg) |-> $past(step && first_byte))
        else $error("scan started without a first byte");

    // The count either restarts or grows by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == '0) || (cnt_reg == $past(cnt_reg) + epbsbo_pkg::CNT_W'(1)))
        else $error("epb count jumped");

    // Test position advances at least as fast as the header byte count
    a_ntp_ge_hbs: assert property (@(posedge clk) disable iff (!rst_n)
        ntp_reg >= epbsbo_pkg::NTP_W'(hbs_reg))
        else $error("test position behind header byte count");

    // An emitted result leaves the scan idle
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> done_reg)
        else $error("scan still running after result");
`endif

endmodule

>>> hw/rtl/epbsbo_out.sv
// Result stage: corrected bit offset computation and output register.
module epbsbo_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  epbsbo_pkg::scan_res_t               res,
    input  epbsbo_pkg::cfg_t                    cfg,
    output logic                                result_valid,
    output logic [epbsbo_pkg::CNT_W-1:0]        epb_count,
    output logic [epbsbo_pkg::OUT_W-1:0]        first_mb_bit_offset
);

    logic                           valid_reg;
    logic [epbsbo_pkg::CNT_W-1:0]   cnt_reg;
    logic [epbsbo_pkg::OUT_W-1:0]   off_reg;
    logic [epbsbo_pkg::SUM_W-1:0]   sum;
    logic [epbsbo_pkg::SUM_W-1:0]   sum_rnd;
    logic [epbsbo_pkg::OUT_W-1:0]   off_next;

    // offset + 8*count, rounded up to a byte in CABAC mode
    always_comb
    begin
        sum      = epbsbo_pkg::SUM_W'(cfg.header_bit_offset)
                   + (epbsbo_pkg::SUM_W'(res.count) << 3);
        sum_rnd  = (sum + epbsbo_pkg::SUM_W'(7)) & ~epbsbo_pkg::SUM_W'(7);
        off_next = cfg.cabac_mode ? sum_rnd[epbsbo_pkg::OUT_W-1:0]
                                  : sum[epbsbo_pkg::OUT_W-1:0];
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            cnt_reg <= res.count;
            off_reg <= off_next;
        end
    end

    assign result_valid        = valid_reg;
    assign epb_count           = cnt_reg;
    assign first_mb_bit_offset = off_reg;

endmodule

>>> hw/rtl/epb_aware_slice_bit_offset.sv
// Top level of the slice bit offset corrector with emulation prevention byte count.
//
// Usage:
//   Item channel (item_valid / item_stall): one raw slice byte per transaction,
//   with first_byte set on byte 0 of each slice. A first byte restarts the scan.
//   Result channel (result_valid / result_stall): one transaction per slice,
//   carrying the emulation prevention byte count and the corrected bit offset
//   of the first macroblock. Bytes after the result and before the next first
//   byte are consumed and produce nothing.
//   Config channel (cfg_valid / cfg_ready): index 0 header bit offset, 1 slice
//   data length, 2 CABAC mode. Always ready; write only while the block is idle.
// Timing:
//   One byte per cycle while no result is held. A byte is taken into the input
//   register, scanned combinationally, and its result is registered in the output
//   register that drives result_valid. The scan updates its whole state for each
//   byte combinationally, which sets the rate.
// Reset: configuration clears to zero, the scan goes idle until a first byte,
//   and both pipeline registers empty.
// Stall: a held result stops the scan stage; the input register still takes
//   one byte if it is empty, then item_stall rises until the result is taken.
module epb_aware_slice_bit_offset (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                first_byte,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [epbsbo_pkg::CNT_W-1:0]        epb_count,
    output logic [epbsbo_pkg::OUT_W-1:0]        first_mb_bit_offset,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [epbsbo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epbsbo_pkg::CFG_DATA_W-1:0]   cfg_data
);

    epbsbo_pkg::cfg_t       cfg;
    epbsbo_pkg::scan_res_t  res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       advance;
    logic       step;

    // Pipeline moves unless a result is held
    assign advance    = !(result_valid && result_stall);
    assign step       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_byte_reg  <= data_byte;
            in_first_reg <= first_byte;
        end
    end

    epbsbo_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    epbsbo_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .cfg        (cfg),
        .res        (res)
    );

    epbsbo_out u_out (
        .clk                 (clk),
        .rst_n               (rst_n),
        .advance             (advance),
        .res                 (res),
        .cfg                 (cfg),
        .result_valid        (result_valid),
        .epb_count           (epb_count),
        .first_mb_bit_offset (first_mb_bit_offset)
    );

endmodule
